// ===== rtl/core/idr_pkg.sv =====
// ----------------------------------------------------------------------------
// idr_pkg
// Shared widths, command codes and per-word side information for the
// integer divide/remainder core.
// ----------------------------------------------------------------------------
package idr_pkg;

	localparam int unsigned DW = 64;
	localparam int unsigned HW = 32;
	localparam int unsigned STEPS = DW;

	typedef enum logic [1:0] {
		CMD_S64 = 2'd0,
		CMD_U64 = 2'd1,
		CMD_S32 = 2'd2,
		CMD_U32 = 2'd3
	} cmd_t;

	typedef struct packed {
		logic neg_q;
		logic neg_r;
		logic zero;
		logic narrow;
	} idr_side_t;

endpackage

// ===== rtl/core/idr_step.sv =====
// ----------------------------------------------------------------------------
// idr_step
// One registered restoring shift-subtract step with its own valid/ready stage.
// ----------------------------------------------------------------------------
module idr_step (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [idr_pkg::DW-1:0]       in_acc,
	input  logic [idr_pkg::DW-1:0]       in_nq,
	input  logic [idr_pkg::DW-1:0]       in_den,
	input  idr_pkg::idr_side_t           in_side,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [idr_pkg::DW-1:0]       out_acc,
	output logic [idr_pkg::DW-1:0]       out_nq,
	output logic [idr_pkg::DW-1:0]       out_den,
	output idr_pkg::idr_side_t           out_side
);

	localparam int unsigned W = idr_pkg::DW;

	logic               valid_q;
	logic [W-1:0]       acc_q;
	logic [W-1:0]       nq_q;
	logic [W-1:0]       den_q;
	idr_pkg::idr_side_t side_q;

	logic               carry;
	logic [W-1:0]       shifted;
	logic [W:0]         diff;
	logic               take;
	logic               load;

	assign carry   = in_acc[W-1];
	assign shifted = {in_acc[W-2:0], in_nq[W-1]};
	assign diff    = {carry, shifted} - {1'b0, in_den};
	assign take    = carry | ~diff[W];

	assign in_ready = ~valid_q | out_ready;
	assign load     = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q  <= take ? diff[W-1:0] : shifted;
			nq_q   <= {in_nq[W-2:0], take};
			den_q  <= in_den;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_acc   = acc_q;
	assign out_nq    = nq_q;
	assign out_den   = den_q;
	assign out_side  = side_q;

endmodule

// ===== rtl/core/integer_divide_remainder_core.sv =====
// ----------------------------------------------------------------------------
// integer_divide_remainder_core
// Pipelined 64/32-bit signed and unsigned divider returning quotient and
// remainder.
// ----------------------------------------------------------------------------
// Takes one word per cycle and returns one result word per cycle in order while the output is not stalled.
// The pipeline holds one operand-preparation stage
// (sign handling and magnitudes), 64 restoring shift-subtract stages of one
// quotient bit each, and one output stage that restores the signs. Each stage
// holds its own word and advances when the stage after it is empty or moving,
// so bubbles close up and a stall at the output only backs up the full part
// of the pipeline. Quotients truncate toward zero, the remainder carries the
// dividend's sign, a zero divisor returns quotient 0 and remainder equal to
// the dividend, and the most negative value over -1 wraps. The 32-bit
// commands use the low halves of the operands and return zero-extended
// results.
// ----------------------------------------------------------------------------
module integer_divide_remainder_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             command,
	input  logic [idr_pkg::DW-1:0] dividend,
	input  logic [idr_pkg::DW-1:0] divisor,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [idr_pkg::DW-1:0] quotient,
	output logic [idr_pkg::DW-1:0] remainder
);

	localparam int unsigned W = idr_pkg::DW;
	localparam int unsigned H = idr_pkg::HW;
	localparam int unsigned N = idr_pkg::STEPS;

	// operand decode
	logic               is_signed;
	logic               narrow;
	logic [W-1:0]       a_ext;
	logic [W-1:0]       b_ext;
	logic               na;
	logic               nb;
	idr_pkg::idr_side_t side_in;

	always_comb begin
		unique case (idr_pkg::cmd_t'(command))
			idr_pkg::CMD_S64: begin
				is_signed = 1'b1;
				narrow    = 1'b0;
			end
			idr_pkg::CMD_U64: begin
				is_signed = 1'b0;
				narrow    = 1'b0;
			end
			idr_pkg::CMD_S32: begin
				is_signed = 1'b1;
				narrow    = 1'b1;
			end
			idr_pkg::CMD_U32: begin
				is_signed = 1'b0;
				narrow    = 1'b1;
			end
			default: begin
				is_signed = 1'b0;
				narrow    = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (narrow) begin
			a_ext = {{(W-H){is_signed & dividend[H-1]}}, dividend[H-1:0]};
			b_ext = {{(W-H){is_signed & divisor[H-1]}}, divisor[H-1:0]};
		end else begin
			a_ext = dividend;
			b_ext = divisor;
		end
	end

	assign na = is_signed & a_ext[W-1];
	assign nb = is_signed & b_ext[W-1];

	assign side_in.neg_q  = na ^ nb;
	assign side_in.neg_r  = na;
	assign side_in.zero   = (b_ext == '0);
	assign side_in.narrow = narrow;

	// preparation stage
	logic               valid_s1;
	logic [W-1:0]       mag_a_s1;
	logic [W-1:0]       mag_b_s1;
	idr_pkg::idr_side_t side_s1;
	logic               ready_s1;

	logic               step_valid [0:N];
	logic               step_ready [0:N];
	logic [W-1:0]       step_acc   [0:N];
	logic [W-1:0]       step_nq    [0:N];
	logic [W-1:0]       step_den   [0:N];
	idr_pkg::idr_side_t step_side  [0:N];

	assign in_ready = ~valid_s1 | ready_s1;
	assign ready_s1 = step_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mag_a_s1 <= na ? ({W{1'b0}} - a_ext) : a_ext;
			mag_b_s1 <= nb ? ({W{1'b0}} - b_ext) : b_ext;
			side_s1  <= side_in;
		end
	end

	assign step_valid[0] = valid_s1;
	assign step_acc[0]   = '0;
	assign step_nq[0]    = mag_a_s1;
	assign step_den[0]   = mag_b_s1;
	assign step_side[0]  = side_s1;

	// shift-subtract stages
	for (genvar g = 0; g < N; g++) begin : g_step
		idr_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (step_valid[g]),
			.in_ready  (step_ready[g]),
			.in_acc    (step_acc[g]),
			.in_nq     (step_nq[g]),
			.in_den    (step_den[g]),
			.in_side   (step_side[g]),
			.out_valid (step_valid[g+1]),
			.out_ready (step_ready[g+1]),
			.out_acc   (step_acc[g+1]),
			.out_nq    (step_nq[g+1]),
			.out_den   (step_den[g+1]),
			.out_side  (step_side[g+1])
		);
	end

	// sign restore and output stage
	logic               valid_s66;
	logic [W-1:0]       quot_s66;
	logic [W-1:0]       rem_s66;
	idr_pkg::idr_side_t side_s66;
	logic [W-1:0]       q_fix;
	logic [W-1:0]       r_fix;
	logic [W-1:0]       keep;

	assign step_ready[N] = ~valid_s66 | out_ready;

	assign keep  = step_side[N].narrow ? {{(W-H){1'b0}}, {H{1'b1}}} : {W{1'b1}};
	assign q_fix = step_side[N].zero ? '0 :
		(step_side[N].neg_q ? ({W{1'b0}} - step_nq[N]) : step_nq[N]);
	assign r_fix = step_side[N].neg_r ? ({W{1'b0}} - step_acc[N]) : step_acc[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s66 <= 1'b0;
		end else if (step_ready[N]) begin
			valid_s66 <= step_valid[N];
		end
	end

	always_ff @(posedge clk) begin
		if (step_valid[N] && step_ready[N]) begin
			quot_s66 <= q_fix & keep;
			rem_s66  <= r_fix & keep;
			side_s66 <= step_side[N];
		end
	end

	assign out_valid = valid_s66;
	assign quotient  = quot_s66;
	assign remainder = rem_s66;

	// checks
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid[N] && !step_side[N].zero |-> step_acc[N] < step_den[N])
		else $error("remainder magnitude not below divisor magnitude");

	a_zero_quot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s66 && side_s66.zero |-> quot_s66 == '0)
		else $error("zero divisor gave nonzero quotient");

	a_narrow_upper: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s66 && side_s66.narrow |-> quot_s66[W-1:H] == '0 && rem_s66[W-1:H] == '0)
		else $error("32-bit result has upper bits set");

	a_prep_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s1 |=> valid_s1 && $stable(mag_a_s1) && $stable(mag_b_s1))
		else $error("preparation stage lost a stalled word");

endmodule
